@@ hw/rtl/bbcd_pkg.sv @@
// Shared types, constants and helper functions of the black border crop detector.
// Used by bbcd_tracker, bbcd_median and black_border_crop_detector_core.
package bbcd_pkg;

  // Largest frame dimension and the number of frames in one median batch.
  localparam int MAX_DIMENSION = 4096;
  localparam int SAMPLE_FRAMES = 5;

  // Widths fixed by the interface fields.
  localparam int CROP_W  = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int COLOR_W = 8;

  // Widths that follow from the constants above.
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int POS_W   = $clog2(MAX_DIMENSION);
  localparam int IDX_W   = (SAMPLE_FRAMES > 1) ? $clog2(SAMPLE_FRAMES) : 1;
  localparam int CNT_W   = $clog2(SAMPLE_FRAMES + 1);

  // A pixel is content when any color has a bit set under this mask.
  localparam logic [COLOR_W-1:0] CONTENT_MASK = 8'hE0;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
  } bbcd_pixel_t;

  typedef struct packed {
    logic [CROP_W-1:0] left_crop;
    logic [CROP_W-1:0] top_crop;
    logic [CROP_W-1:0] right_crop;
    logic [CROP_W-1:0] bottom_crop;
    logic [CROP_W-1:0] median_left;
    logic [CROP_W-1:0] median_top;
    logic [CROP_W-1:0] median_right;
    logic [CROP_W-1:0] median_bottom;
    logic              median_valid;
  } bbcd_result_t;

  // Four crops of one frame, as stored in the sample memory.
  typedef struct packed {
    logic [CROP_W-1:0] left;
    logic [CROP_W-1:0] top;
    logic [CROP_W-1:0] right;
    logic [CROP_W-1:0] bottom;
  } bbcd_sample_t;

  // Content extent of the frame so far.
  typedef struct packed {
    logic             seen;
    logic [POS_W-1:0] min_row;
    logic [POS_W-1:0] max_row;
    logic [POS_W-1:0] min_col;
    logic [POS_W-1:0] max_col;
  } bbcd_stats_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROP,
    ST_STORE,
    ST_MEDIAN,
    ST_EMIT
  } bbcd_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LOAD,
    MS_CAND,
    MS_SCAN,
    MS_DONE
  } bbcd_med_state_t;

  typedef enum logic [1:0] {
    EDGE_LEFT,
    EDGE_TOP,
    EDGE_RIGHT,
    EDGE_BOTTOM
  } bbcd_edge_t;

  // A dimension register of zero acts as one; larger than the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bbcd_tracker.sv @@
// Raster position counters and content extent tracking for one frame.
// Depends on bbcd_pkg.
module bbcd_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       beat,
  input  bbcd_pkg::bbcd_pixel_t      pixel,
  input  logic [bbcd_pkg::DIM_W-1:0] frame_w,
  input  logic [bbcd_pkg::DIM_W-1:0] frame_h,
  input  logic                       restart,
  output logic                       last_pixel,
  output bbcd_pkg::bbcd_stats_t      stats
);
  import bbcd_pkg::*;

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  logic             last_col;
  logic             last_row;
  logic             content;

  // End of row and end of frame for the pixel on the input now.
  assign last_col   = (DIM_W'(col) + DIM_W'(1)) >= frame_w;
  assign last_row   = (DIM_W'(row) + DIM_W'(1)) >= frame_h;
  assign last_pixel = last_col && last_row;
  assign content    = ((pixel.pixel_red | pixel.pixel_green | pixel.pixel_blue)
                       & CONTENT_MASK) != '0;

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (beat) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

  // Content extent; the bounds only mean something once seen is set.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      stats.seen <= 1'b0;
    end else if (beat && content) begin
      stats.seen <= 1'b1;
      if (!stats.seen) begin
        stats.min_row <= row;
        stats.max_row <= row;
        stats.min_col <= col;
        stats.max_col <= col;
      end else begin
        if (row < stats.min_row) stats.min_row <= row;
        if (row > stats.max_row) stats.max_row <= row;
        if (col < stats.min_col) stats.min_col <= col;
        if (col > stats.max_col) stats.max_col <= col;
      end
    end
  end

endmodule

@@ hw/rtl/bbcd_median.sv @@
// Sample memory for the crops of one batch and an iterative median finder
// built around a single shared compare unit. Depends on bbcd_pkg.
module bbcd_median (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [bbcd_pkg::IDX_W-1:0] wr_slot,
  input  bbcd_pkg::bbcd_sample_t     wr_data,
  input  logic                       start,
  output logic                       done,
  output bbcd_pkg::bbcd_sample_t     median
);
  import bbcd_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SAMPLE_FRAMES - 1);
  localparam logic [IDX_W-1:0] MID  = IDX_W'(SAMPLE_FRAMES / 2);

  bbcd_sample_t    mem [SAMPLE_FRAMES];
  bbcd_sample_t    rd_word;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_addr;

  bbcd_med_state_t state;
  bbcd_med_state_t state_next;
  bbcd_edge_t      edge_sel;
  bbcd_edge_t      edge_after;
  logic [IDX_W-1:0] cand_idx;
  logic [CROP_W-1:0] cand;
  logic [IDX_W-1:0] rank;
  logic [IDX_W-1:0] rank_next;
  logic [CROP_W-1:0] lane;
  logic              hit;
  logic              scan_end;

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    rd_word <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  // Edge lane of the word just read.
  always_comb begin
    case (edge_sel)
      EDGE_LEFT:   lane = rd_word.left;
      EDGE_TOP:    lane = rd_word.top;
      EDGE_RIGHT:  lane = rd_word.right;
      EDGE_BOTTOM: lane = rd_word.bottom;
      default:     lane = rd_word.left;
    endcase
  end

  // Shared compare unit: the rank of the candidate, with ties broken by index.
  assign hit       = (lane < cand) || ((lane == cand) && (rd_idx < cand_idx));
  assign rank_next = rank + IDX_W'(hit);
  assign scan_end  = (rd_idx == LAST);

  always_comb begin
    case (edge_sel)
      EDGE_LEFT:   edge_after = EDGE_TOP;
      EDGE_TOP:    edge_after = EDGE_RIGHT;
      EDGE_RIGHT:  edge_after = EDGE_BOTTOM;
      default:     edge_after = EDGE_LEFT;
    endcase
  end

  // Sequencer: next state and read address.
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    done       = 1'b0;
    case (state)
      MS_IDLE: begin
        if (start) state_next = MS_LOAD;
      end
      MS_LOAD: begin
        rd_addr    = cand_idx;
        state_next = MS_CAND;
      end
      MS_CAND: begin
        rd_addr    = '0;
        state_next = MS_SCAN;
      end
      MS_SCAN: begin
        rd_addr = scan_end ? '0 : rd_idx + IDX_W'(1);
        if (scan_end) begin
          if ((cand_idx == LAST) && (edge_sel == EDGE_BOTTOM)) begin
            state_next = MS_DONE;
          end else begin
            state_next = MS_LOAD;
          end
        end
      end
      MS_DONE: begin
        done       = 1'b1;
        state_next = MS_IDLE;
      end
      default: state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters, candidate and rank registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_sel <= EDGE_LEFT;
      cand_idx <= '0;
    end else begin
      case (state)
        MS_IDLE: begin
          if (start) begin
            edge_sel <= EDGE_LEFT;
            cand_idx <= '0;
          end
        end
        MS_SCAN: begin
          if (scan_end) begin
            if (cand_idx == LAST) begin
              cand_idx <= '0;
              edge_sel <= edge_after;
            end else begin
              cand_idx <= cand_idx + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MS_CAND: begin
        cand <= lane;
        rank <= '0;
      end
      MS_SCAN: begin
        rank <= rank_next;
        if (scan_end && (rank_next == MID)) begin
          case (edge_sel)
            EDGE_LEFT:   median.left   <= cand;
            EDGE_TOP:    median.top    <= cand;
            EDGE_RIGHT:  median.right  <= cand;
            EDGE_BOTTOM: median.bottom <= cand;
            default:     median.left   <= cand;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/black_border_crop_detector_core.sv @@
// Top level of the black border crop detector: configuration registers, frame end
// sequencer and output register. Depends on bbcd_pkg, bbcd_tracker, bbcd_median.
//
//   channel  direction  handshake              payload
//   pixel    in         pixel_valid/ready      bbcd_pixel_t, one RGB pixel in raster order
//   crop     out        crop_valid/ready       bbcd_result_t, crops and medians of a frame
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// Pixels are taken one per cycle while the sequencer is idle. The last pixel of a
// frame is followed by the crop, store and emit steps; when it completes a batch the
// median finder runs between store and emit, one compare per cycle while it scans.
// A frame result waits in the output register while pixels of the next frame flow;
// the next frame end stalls in the emit step until that register is taken.
// Reset is synchronous and restores 640 by 480 and an empty batch.
module black_border_crop_detector_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  bbcd_pkg::bbcd_pixel_t       pixel,
  output logic                        crop_valid,
  input  logic                        crop_ready,
  output bbcd_pkg::bbcd_result_t      crop,
  input  logic                        cfg_write,
  input  logic [bbcd_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bbcd_pkg::CFG_W-1:0]  cfg_data
);
  import bbcd_pkg::*;

  localparam int RND_W = DIM_W + 2;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [DIM_W-1:0] frame_w;
  logic [DIM_W-1:0] frame_h;

  bbcd_state_t      state;
  bbcd_state_t      state_next;
  logic             beat;
  logic             last_pixel;
  logic             restart;
  logic             cfg_dim;
  bbcd_stats_t      stats;

  logic [CNT_W-1:0] frames_in_batch;
  logic [CNT_W-1:0] slot;
  logic [CNT_W-1:0] slot_inc;
  logic             batch_full;
  logic             batch_done;

  bbcd_sample_t     crops;
  bbcd_sample_t     crops_calc;
  bbcd_sample_t     median;
  logic             med_start;
  logic             med_done;
  logic             wr_en;
  logic             emit;

  logic [DIM_W-1:0] lead_rows;
  logic [DIM_W-1:0] trail_rows;
  logic [DIM_W-1:0] lead_cols;
  logic [DIM_W-1:0] trail_cols;
  logic [DIM_W-1:0] h_m1;
  logic [DIM_W-1:0] w_m1;

  // Configuration registers; a dimension write restarts the frame.
  assign cfg_dim = cfg_write && ((cfg_index == REG_FRAME_WIDTH) ||
                                 (cfg_index == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH)  frame_width  <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  assign frame_w = clamp_dim(frame_width);
  assign frame_h = clamp_dim(frame_height);

  assign pixel_ready = (state == ST_IDLE);
  assign beat        = pixel_valid && pixel_ready;
  assign restart     = cfg_dim || (state == ST_CROP);

  bbcd_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .pixel      (pixel),
    .frame_w    (frame_w),
    .frame_h    (frame_h),
    .restart    (restart),
    .last_pixel (last_pixel),
    .stats      (stats)
  );

  // Crops from the content extent, rounded up to 4 columns and 2 rows.
  function automatic logic [CROP_W-1:0] round_up(input logic [DIM_W-1:0] v,
                                                 input logic [RND_W-1:0] lsbs);
    logic [RND_W-1:0] t;
    t = (RND_W'(v) + lsbs) & ~lsbs;
    return CROP_W'(t);
  endfunction

  assign h_m1 = frame_h - DIM_W'(1);
  assign w_m1 = frame_w - DIM_W'(1);

  always_comb begin
    if (stats.seen) begin
      lead_rows  = DIM_W'(stats.min_row);
      trail_rows = (DIM_W'(stats.max_row) >= h_m1) ? '0 : h_m1 - DIM_W'(stats.max_row);
      lead_cols  = DIM_W'(stats.min_col);
      trail_cols = (DIM_W'(stats.max_col) >= w_m1) ? '0 : w_m1 - DIM_W'(stats.max_col);
    end else begin
      lead_rows  = frame_h;
      trail_rows = frame_h;
      lead_cols  = frame_w;
      trail_cols = frame_w;
    end
    crops_calc.left   = round_up(lead_cols,  RND_W'(3));
    crops_calc.top    = round_up(trail_rows, RND_W'(1));
    crops_calc.right  = round_up(trail_cols, RND_W'(3));
    crops_calc.bottom = round_up(lead_rows,  RND_W'(1));
  end

  always_ff @(posedge clk) begin
    if (state == ST_CROP) crops <= crops_calc;
  end

  // Batch slot bookkeeping.
  assign slot       = (32'(frames_in_batch) >= SAMPLE_FRAMES) ? '0 : frames_in_batch;
  assign slot_inc   = slot + CNT_W'(1);
  assign batch_full = 32'(slot_inc) >= SAMPLE_FRAMES;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_batch <= '0;
      batch_done      <= 1'b0;
    end else if (state == ST_STORE) begin
      frames_in_batch <= batch_full ? '0 : slot_inc;
      batch_done      <= batch_full;
    end
  end

  assign wr_en     = (state == ST_STORE);
  assign med_start = (state == ST_STORE) && batch_full;

  bbcd_median u_median (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_slot (slot[IDX_W-1:0]),
    .wr_data (crops),
    .start   (med_start),
    .done    (med_done),
    .median  (median)
  );

  // Frame end sequencer.
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (beat && last_pixel) state_next = ST_CROP;
      end
      ST_CROP: begin
        state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = batch_full ? ST_MEDIAN : ST_EMIT;
      end
      ST_MEDIAN: begin
        if (med_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!crop_valid || crop_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crop_valid <= 1'b0;
    end else if (emit) begin
      crop_valid <= 1'b1;
    end else if (crop_ready) begin
      crop_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      crop.left_crop     <= crops.left;
      crop.top_crop      <= crops.top;
      crop.right_crop    <= crops.right;
      crop.bottom_crop   <= crops.bottom;
      crop.median_left   <= batch_done ? median.left   : '0;
      crop.median_top    <= batch_done ? median.top    : '0;
      crop.median_right  <= batch_done ? median.right  : '0;
      crop.median_bottom <= batch_done ? median.bottom : '0;
      crop.median_valid  <= batch_done;
    end
  end

endmodule

@@ test/tb_black_border_crop_detector_core.sv @@
// Self-checking testbench of black_border_crop_detector_core: streams pixel frames of many
// sizes, predicts the per-frame crops and batch medians, and checks every crop beat.
// Depends on bbcd_pkg and the black_border_crop_detector_core RTL.
`timescale 1ns / 1ps

module tb_black_border_crop_detector_core;
  import bbcd_pkg::*;

  // Register indexes that the block has no register behind.
  localparam logic [CIDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_B = 2'd3;

  // Cycles the block may still need after the last crop beat (median pass plus margin).
  localparam int SETTLE_CYCLES = 4 * SAMPLE_FRAMES * (SAMPLE_FRAMES + 2) + 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  // Tracks content extents exactly as the block should and keeps the crops still owed.
  class crop_scoreboard;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    int                col;
    int                row;
    int                min_row;
    int                max_row;
    int                min_col;
    int                max_col;
    int                batch_fill;
    bit                seen;
    logic [CROP_W-1:0] left_hist[SAMPLE_FRAMES];
    logic [CROP_W-1:0] top_hist[SAMPLE_FRAMES];
    logic [CROP_W-1:0] right_hist[SAMPLE_FRAMES];
    logic [CROP_W-1:0] bottom_hist[SAMPLE_FRAMES];
    bbcd_result_t      pending_crops[$];
    int                errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      batch_fill = 0;
      errors     = 0;
      for (int i = 0; i < SAMPLE_FRAMES; i++) begin
        left_hist[i]   = '0;
        top_hist[i]    = '0;
        right_hist[i]  = '0;
        bottom_hist[i] = '0;
      end
      restart_frame();
    endfunction

    function void restart_frame();
      col     = 0;
      row     = 0;
      seen    = 1'b0;
      min_row = 0;
      max_row = 0;
      min_col = 0;
      max_col = 0;
    endfunction

    // Zero behaves as one and anything past the maximum saturates.
    function int limit_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return int'(v);
    endfunction

    function int frame_cols();
      return limit_dim(width_reg);
    endfunction

    function int frame_rows();
      return limit_dim(height_reg);
    endfunction

    function void write_reg(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_FRAME_WIDTH: begin
          width_reg = data;
          restart_frame();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
          restart_frame();
        end
        default: begin
          // Spare indexes change nothing, not even the frame position.
        end
      endcase
    endfunction

    function int round_up(int v, int step);
      return ((v + step - 1) / step) * step;
    endfunction

    function logic [CROP_W-1:0] median_of(logic [CROP_W-1:0] vals[SAMPLE_FRAMES]);
      logic [CROP_W-1:0] sorted[SAMPLE_FRAMES];
      logic [CROP_W-1:0] key;
      int                j;
      sorted = vals;
      for (int i = 1; i < SAMPLE_FRAMES; i++) begin
        key = sorted[i];
        j   = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = key;
      end
      return sorted[SAMPLE_FRAMES / 2];
    endfunction

    // Called for every accepted pixel beat; queues a crop result on the last pixel of a frame.
    function void take_pixel(bbcd_pixel_t p);
      int           cols;
      int           rows;
      int           lead_rows;
      int           trail_rows;
      int           lead_cols;
      int           trail_cols;
      bbcd_result_t res;
      cols = frame_cols();
      rows = frame_rows();

      // Extend the content box.
      if (((p.pixel_red | p.pixel_green | p.pixel_blue) & CONTENT_MASK) != 0) begin
        if (!seen) begin
          min_row = row;
          max_row = row;
          min_col = col;
          max_col = col;
          seen    = 1'b1;
        end else begin
          if (row < min_row) min_row = row;
          if (row > max_row) max_row = row;
          if (col < min_col) min_col = col;
          if (col > max_col) max_col = col;
        end
      end

      // Advance the raster position.
      if (col + 1 < cols) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < rows) begin
        row++;
        return;
      end

      // Frame end: a frame with no content crops its whole height and width.
      if (seen) begin
        lead_rows  = min_row;
        trail_rows = rows - 1 - max_row;
        lead_cols  = min_col;
        trail_cols = cols - 1 - max_col;
      end else begin
        lead_rows  = rows;
        trail_rows = rows;
        lead_cols  = cols;
        trail_cols = cols;
      end
      res             = '0;
      res.left_crop   = CROP_W'(round_up(lead_cols, 4));
      res.top_crop    = CROP_W'(round_up(trail_rows, 2));
      res.right_crop  = CROP_W'(round_up(trail_cols, 4));
      res.bottom_crop = CROP_W'(round_up(lead_rows, 2));

      // Store this frame in the batch; the last frame of a batch carries the medians.
      left_hist[batch_fill]   = res.left_crop;
      top_hist[batch_fill]    = res.top_crop;
      right_hist[batch_fill]  = res.right_crop;
      bottom_hist[batch_fill] = res.bottom_crop;
      batch_fill++;
      if (batch_fill >= SAMPLE_FRAMES) begin
        res.median_left   = median_of(left_hist);
        res.median_top    = median_of(top_hist);
        res.median_right  = median_of(right_hist);
        res.median_bottom = median_of(bottom_hist);
        res.median_valid  = 1'b1;
        batch_fill        = 0;
      end
      pending_crops.push_back(res);
      restart_frame();
    endfunction

    function void compare(string field, logic [CROP_W-1:0] want, logic [CROP_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Called for every accepted crop beat.
    function void check_crop(bbcd_result_t got);
      bbcd_result_t want;
      if (pending_crops.size() == 0) begin
        errors++;
        $display("%0t: crop beat with no frame end pending: expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_crops.pop_front();
      compare("left_crop", want.left_crop, got.left_crop);
      compare("top_crop", want.top_crop, got.top_crop);
      compare("right_crop", want.right_crop, got.right_crop);
      compare("bottom_crop", want.bottom_crop, got.bottom_crop);
      compare("median_left", want.median_left, got.median_left);
      compare("median_top", want.median_top, got.median_top);
      compare("median_right", want.median_right, got.median_right);
      compare("median_bottom", want.median_bottom, got.median_bottom);
      compare("median_valid", CROP_W'(want.median_valid), CROP_W'(got.median_valid));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               pixel_valid;
  logic               pixel_ready;
  bbcd_pixel_t        pixel;
  logic               crop_valid;
  logic               crop_ready = 1'b0;
  bbcd_result_t       crop;
  logic               cfg_write;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               hold_request;
  bit                 hold_done = 1'b0;

  crop_scoreboard board;
  int             sender_idle = 0;
  int             recv_idle = 0;
  int             stall_left = 0;
  int             pixels_sent = 0;
  int             cycle_count = 0;

  black_border_crop_detector_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .crop_valid  (crop_valid),
    .crop_ready  (crop_ready),
    .crop        (crop),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_black_border_crop_detector_core: FAIL");
      $finish;
    end
  end

  // Crop receiver: checks each beat, stalls at random and holds off once on request.
  always @(posedge clk) begin
    if (rst) begin
      crop_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (crop_valid && crop_ready) begin
        board.check_crop(crop);
      end
      if (hold_request && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        crop_ready <= 1'b0;
      end else begin
        crop_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Black pixels keep every color under 32; content pixels push one color to 32 or more.
  function automatic bbcd_pixel_t make_pixel(bit content);
    bbcd_pixel_t p;
    if (content) begin
      p.pixel_red   = COLOR_W'($urandom_range(0, 255));
      p.pixel_green = COLOR_W'($urandom_range(0, 255));
      p.pixel_blue  = COLOR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: p.pixel_red = COLOR_W'($urandom_range(32, 255));
        1: p.pixel_green = COLOR_W'($urandom_range(32, 255));
        default: p.pixel_blue = COLOR_W'($urandom_range(32, 255));
      endcase
    end else begin
      p.pixel_red   = COLOR_W'($urandom_range(0, 31));
      p.pixel_green = COLOR_W'($urandom_range(0, 31));
      p.pixel_blue  = COLOR_W'($urandom_range(0, 31));
    end
    return p;
  endfunction

  // Offers one pixel beat, waits for it to be taken, then maybe idles.
  task automatic send_pixel(bbcd_pixel_t p);
    int gap;
    gap = 0;
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    board.take_pixel(p);
    pixels_sent++;
    while ($urandom_range(0, 99) < sender_idle) gap++;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends the first pixel_count pixels of a frame with a randomly chosen content layout.
  task automatic send_frame(int pixel_count);
    int cols;
    int rows;
    int layout;
    int r0;
    int r1;
    int c0;
    int c1;
    int sent;
    bit hit;
    cols   = board.frame_cols();
    rows   = board.frame_rows();
    layout = $urandom_range(0, 9);
    r0     = $urandom_range(0, rows - 1);
    r1     = $urandom_range(r0, rows - 1);
    c0     = $urandom_range(0, cols - 1);
    c1     = $urandom_range(c0, cols - 1);
    sent   = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (sent >= pixel_count) return;
        if (layout < 2) begin
          hit = 1'b0;
        end else if (layout < 5) begin
          hit = (r == r0 && c == c0);
        end else if (layout < 9) begin
          // Box with content on two opposite corners and scattered inside.
          hit = (r == r0 && c == c0) || (r == r1 && c == c1) ||
                (r >= r0 && r <= r1 && c >= c0 && c <= c1 && $urandom_range(0, 9) < 3);
        end else begin
          hit = ($urandom_range(0, 9) == 0);
        end
        send_pixel(make_pixel(hit));
        sent++;
      end
    end
  endtask

  // Stops offering pixels until every owed crop has arrived.
  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (board.pending_crops.size() != 0) @(posedge clk);
  endtask

  // Lets the block finish any median pass before touching the registers.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(index, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] width_val, logic [CFG_W-1:0] height_val);
    settle();
    write_reg(REG_FRAME_WIDTH, width_val);
    write_reg(REG_FRAME_HEIGHT, height_val);
  endtask

  initial begin
    int          w;
    int          h;
    int          n;
    int          full;
    int          phase_start;
    int          phase_frames;
    bbcd_pixel_t p;
    board        = new();
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one 5x3 frame with a single content pixel; spare register writes mid-frame
    // must neither change anything nor restart the frame.
    sender_idle = 10;
    recv_idle   = 10;
    configure(13'd5, 13'd3);
    for (int i = 0; i < 15; i++) begin
      if (i == 6) begin
        settle();
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0000);
      end
      if (i == 7) begin
        p = '{pixel_red: 8'h00, pixel_green: 8'h00, pixel_blue: 8'hE0};
      end else begin
        p = make_pixel(1'b0);
      end
      send_pixel(p);
    end

    // Directed: zero dimensions act as 1x1, so each pixel is a frame; covers the content
    // threshold on every color, the extremes of the colors, and a batch completing.
    configure(13'd0, 13'd0);
    send_pixel('{pixel_red: 8'h00, pixel_green: 8'h00, pixel_blue: 8'h00});
    send_pixel('{pixel_red: 8'h1F, pixel_green: 8'h1F, pixel_blue: 8'h1F});
    send_pixel('{pixel_red: 8'h20, pixel_green: 8'h00, pixel_blue: 8'h00});
    send_pixel('{pixel_red: 8'h00, pixel_green: 8'h20, pixel_blue: 8'h00});
    send_pixel('{pixel_red: 8'h00, pixel_green: 8'h00, pixel_blue: 8'h20});
    send_pixel('{pixel_red: 8'hFF, pixel_green: 8'hFF, pixel_blue: 8'hFF});
    send_pixel('{pixel_red: 8'h80, pixel_green: 8'h40, pixel_blue: 8'h1F});

    // A register write in the middle of a frame restarts it.
    configure(13'd5, 13'd3);
    repeat (3) send_pixel(make_pixel(1'($urandom_range(0, 1))));

    // Random frames in three idling mixes.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle = 21;
          recv_idle   = 61;
        end
        1: begin
          sender_idle = 61;
          recv_idle   = 21;
        end
        default: begin
          sender_idle = 0;
          recv_idle   = 0;
        end
      endcase
      phase_start  = pixels_sent;
      phase_frames = 0;
      while (pixels_sent - phase_start < 80 || phase_frames < 10) begin
        case ($urandom_range(0, 9))
          0: begin
            w = 0;
            h = $urandom_range(1, 4);
          end
          1: begin
            w = $urandom_range(1, 6);
            h = 0;
          end
          2: begin
            w = $urandom_range(16, 40);
            h = $urandom_range(1, 2);
          end
          default: begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
          end
        endcase
        configure(CFG_W'(w), CFG_W'(h));
        full = board.frame_cols() * board.frame_rows();
        n    = $urandom_range(2, 7);
        repeat (n) send_frame(full);
        phase_frames += n;
        // Sometimes leave a frame unfinished so the next write restarts it.
        if (full > 1 && $urandom_range(0, 4) == 0) begin
          send_frame($urandom_range(1, full - 1));
        end
      end
    end

    // Back-pressure: the receiver holds off while small frames keep coming, so the block
    // must stall its input; then the sender pauses until every crop is in.
    configure(13'd2, 13'd2);
    sender_idle = 0;
    recv_idle   = 0;
    hold_request <= 1'b1;
    repeat (12) send_frame(4);
    drain_results();
    repeat (6) send_frame(4);

    settle();
    if (board.errors == 0) begin
      $display("tb_black_border_crop_detector_core: PASS");
    end else begin
      $display("tb_black_border_crop_detector_core: FAIL");
    end
    $finish;
  end

endmodule
